@@ rtl/core/stcs_pkg.sv @@
// Package for the stereo triode crossover shaper.
// Holds the sample format, payload structs, register indexes and fixed-point constants.
// No dependencies.
package stcs_pkg;

    localparam int QB            = 28;
    localparam int SAMPLE_BITS   = 24;
    localparam int FRACTION_BITS = 22;

    typedef enum logic [1:0] {
        REG_TRIODE_GAIN = 2'd0,
        REG_SOFT_AMOUNT = 2'd1,
        REG_HARD_AMOUNT = 2'd2,
        REG_WET_MIX     = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_sample;
        logic signed [SAMPLE_BITS-1:0] right_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
    } t_out_item;

    typedef struct packed {
        logic [23:0] triode_gain;
        logic [21:0] soft_amount;
        logic [21:0] hard_amount;
        logic [16:0] wet_mix;
    } t_cfg;

    localparam logic [29:0] PI2_Q   = 30'd421657429;
    localparam logic [27:0] HALF_Q  = 28'd134217728;
    localparam logic [18:0] GOFF_Q  = 19'd268435;
    localparam logic [16:0] FULL_WET = 17'd65536;

endpackage

@@ rtl/core/stereo_triode_crossover_shaper.sv @@
// Top level of the stereo triode crossover shaper.
// Depends on stcs_pkg and stcs_channel.
// A request is accepted at every rising edge with start high; busy never
// rises, so one sample pair can enter each clock. Both channels run through a
// pipeline whose depth is set mostly by the 40-step divider of the triode
// stage and the 28-step square root of the soft crossover. Each result is
// shown on o_item, marked by o_done for one cycle, when its request leaves
// the last pipeline stage; the receiver cannot stall the block.
module stereo_triode_crossover_shaper (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  stcs_pkg::t_in_item  i_item,
    output logic                o_done,
    output stcs_pkg::t_out_item o_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    import stcs_pkg::*;

    t_cfg r_cfg;
    logic l_valid;
    logic r_valid;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_TRIODE_GAIN: r_cfg.triode_gain <= i_cfg_data[23:0];
                REG_SOFT_AMOUNT: r_cfg.soft_amount <= i_cfg_data[21:0];
                REG_HARD_AMOUNT: r_cfg.hard_amount <= i_cfg_data[21:0];
                REG_WET_MIX:     r_cfg.wet_mix     <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    stcs_channel u_left (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(start),
        .i_sample(i_item.left_sample), .i_cfg(r_cfg),
        .o_valid(l_valid), .o_sample(o_item.left_out)
    );
    stcs_channel u_right (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(start),
        .i_sample(i_item.right_sample), .i_cfg(r_cfg),
        .o_valid(r_valid), .o_sample(o_item.right_out)
    );

    assign o_done = l_valid & r_valid;

endmodule

@@ rtl/core/stcs_channel.sv @@
// One channel of the shaper, as a deep pipeline with a valid bit per stage.
// Depends on stcs_pkg.
module stcs_channel (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic signed [stcs_pkg::SAMPLE_BITS-1:0] i_sample,
    input  stcs_pkg::t_cfg                         i_cfg,
    output logic                                   o_valid,
    output logic signed [stcs_pkg::SAMPLE_BITS-1:0] o_sample
);
    import stcs_pkg::*;

    localparam int SHL = (FRACTION_BITS < QB) ? QB - FRACTION_BITS : 0;
    localparam int SHR = (FRACTION_BITS > QB) ? FRACTION_BITS - QB : 0;
    // Internal signed word; triode output can reach about 2^38 / G growth.
    localparam int W   = 48;
    localparam int DB  = 40;   // divide quotient bits
    localparam int SQB = 28;   // sqrt result bits
    localparam int NS  = 6;
    localparam int LAT = 2 + 2 * NS + 2 + DB + 1 + SQB + 4;
    localparam int RECIP_SH = 38;

    function automatic logic [W-1:0] mag_f(input logic signed [W-1:0] v);
        return v[W-1] ? W'(-v) : W'(v);
    endfunction

    function automatic logic [29:0] sdiv(input int k);
        case (k)
            0: return 30'd156;
            1: return 30'd110;
            2: return 30'd72;
            3: return 30'd42;
            4: return 30'd20;
            default: return 30'd6;
        endcase
    endfunction

    // Series divisors as reciprocals rounded up, scaled by 2^RECIP_SH. The
    // quotient is exact because every dividend stays below 2^30.
    function automatic logic [35:0] srecip(input int k);
        case (k)
            0: return 36'd1762037866;
            1: return 36'd2498890064;
            2: return 36'd3817748708;
            3: return 36'd6544712071;
            4: return 36'd13743895348;
            default: return 36'd45812984491;
        endcase
    endfunction

    // Sine of HALF_Q, a constant fixed by the same series.
    function automatic logic [29:0] sine_c(input logic [29:0] a);
        logic [59:0] x2;
        logic [59:0] t;
        logic [59:0] p;
        x2 = (60'(a) * 60'(a)) >> QB;
        t  = 60'd1 << QB;
        for (int i = 0; i < NS; i++) begin
            p = (x2 * t) >> QB;
            t = (60'd1 << QB) - p / 60'(sdiv(i));
        end
        return 30'((60'(a) * t) >> QB);
    endfunction

    localparam logic [29:0] SIN_HALF = sine_c(30'(HALF_Q));

    // Per-stage carried state
    typedef struct packed {
        logic                 v;
        logic signed [W-1:0]  x;   // input in Q28
        logic signed [W-1:0]  y;   // working value
        logic [29:0]          a;
        logic [29:0]          x2;
        logic [29:0]          t;
        logic                 neg;
        logic [W-1:0]         rem;
        logic [W-1:0]         q;
        logic [W-1:0]         rad;
        logic [W-1:0]         root;
    } t_st;

    localparam int NST = LAT + 1;
    t_st r_st [NST];
    t_st n_st [NST];

    logic signed [W-1:0] x_in;
    logic [W-1:0]        gq;
    assign gq = W'({i_cfg.triode_gain, 8'd0}) + W'(GOFF_Q);

    always_comb begin
        logic signed [W-1:0] xs;
        xs   = W'(i_sample);
        x_in = SHR > 0 ? (xs >>> SHR) : (xs <<< SHL);
    end

    // Stage index bases
    localparam int S_P   = 1;          // |x|*G product
    localparam int S_A   = 2;          // clamp, x2
    localparam int S_SN  = 3;          // series: 2 stages per term
    localparam int S_SE  = S_SN + 2 * NS;
    localparam int S_DV  = S_SE + 1;   // restoring divide, DB stages
    localparam int S_DE  = S_DV + DB;
    localparam int S_SQ  = S_DE + 1;   // sqrt, SQB stages
    localparam int S_SF  = S_SQ + SQB;

    always_comb begin
        logic [W-1:0]        m;
        logic [95:0]         pr;
        logic signed [W-1:0] sv;
        logic [W-1:0]        tr;
        logic [W-1:0]        bb;
        logic [W-1:0]        hh;
        logic [16:0]         w;
        logic signed [W+18:0] mx;
        for (int s = 0; s < NST; s++) n_st[s] = '0;
        n_st[0]   = '0;
        n_st[0].v = i_valid;
        n_st[0].x = x_in;
        n_st[0].y = x_in;
        for (int s = 1; s < NST; s++) begin
            n_st[s] = r_st[s-1];
            m = '0; pr = '0; sv = '0; tr = '0; bb = '0; hh = '0; w = '0; mx = '0;
            if (s == S_P) begin
                m  = mag_f(r_st[s-1].y);
                pr = (96'(m) * 96'(gq)) >> QB;
                sv = r_st[s-1].y[W-1] ? -W'(pr) : W'(pr);
                n_st[s].y = sv - W'(HALF_Q);
            end else if (s == S_A) begin
                m  = mag_f(r_st[s-1].y);
                n_st[s].neg = !(r_st[s-1].y > 0);
                n_st[s].a  = (m > W'(PI2_Q)) ? PI2_Q : m[29:0];
                pr = (96'(n_st[s].a) * 96'(n_st[s].a)) >> QB;
                n_st[s].x2 = pr[29:0];
                n_st[s].t  = 30'd1 << QB;
            end else if (s >= S_SN && s < S_SE) begin
                if (((s - S_SN) % 2) == 0) begin
                    pr = (96'(r_st[s-1].x2) * 96'(r_st[s-1].t)) >> QB;
                    n_st[s].t = pr[29:0];
                end else begin
                    pr = (96'(r_st[s-1].t) * 96'(srecip((s - S_SN) / 2))) >> RECIP_SH;
                    n_st[s].t = (30'd1 << QB) - pr[29:0];
                end
            end else if (s == S_SE) begin
                pr = (96'(r_st[s-1].a) * 96'(r_st[s-1].t)) >> QB;
                sv = r_st[s-1].neg ? -W'(pr) : W'(pr);
                sv = sv + W'(SIN_HALF);
                n_st[s].neg = sv[W-1];
                // The dividend is |sv| * 2^QB. Its bits above the quotient width
                // start in the remainder, which always stays below G.
                n_st[s].rem = mag_f(sv) >> (DB - QB);
                n_st[s].rad = mag_f(sv) << (W - DB + QB);
                n_st[s].q   = '0;
            end else if (s >= S_DV && s < S_DE) begin
                tr = {r_st[s-1].rem[W-2:0], r_st[s-1].rad[W-1]};
                n_st[s].rad = r_st[s-1].rad << 1;
                if (tr >= gq) begin
                    n_st[s].rem = tr - gq;
                    n_st[s].q   = {r_st[s-1].q[W-2:0], 1'b1};
                end else begin
                    n_st[s].rem = tr;
                    n_st[s].q   = {r_st[s-1].q[W-2:0], 1'b0};
                end
                n_st[s].rad = {r_st[s-1].rad[W-2:0], 1'b0};
            end else if (s == S_DE) begin
                if (i_cfg.triode_gain != '0)
                    n_st[s].y = r_st[s-1].neg ? -W'(r_st[s-1].q) : W'(r_st[s-1].q);
                else
                    n_st[s].y = r_st[s-1].x;
                // The radicand |y| * 2^16 spans 2*SQB bits; its top W bits are
                // kept, and the low bits that fall off are all zero.
                n_st[s].rad = mag_f(n_st[s].y) << (16 + W - 2 * SQB);
                n_st[s].rem = '0;
                n_st[s].root = '0;
            end else if (s >= S_SQ && s < S_SF) begin
                // Digit-per-stage square root over 2*SQB bits, MSB first.
                tr = {r_st[s-1].rem[W-3:0], r_st[s-1].rad[W-1 -: 2]};
                n_st[s].rad = r_st[s-1].rad << 2;
                bb = {r_st[s-1].root[W-3:0], 2'b01};
                if (tr >= bb) begin
                    n_st[s].rem  = tr - bb;
                    n_st[s].root = {r_st[s-1].root[W-2:0], 1'b1};
                end else begin
                    n_st[s].rem  = tr;
                    n_st[s].root = {r_st[s-1].root[W-2:0], 1'b0};
                end
            end else if (s == S_SF) begin
                m = mag_f(r_st[s-1].y);
                pr = ((96'(m) + 96'(r_st[s-1].root << 6)) * 96'(i_cfg.soft_amount)) >> 24;
                bb = (m > W'(pr)) ? m - W'(pr) : '0;
                if (i_cfg.soft_amount != '0)
                    n_st[s].y = (r_st[s-1].y > 0) ? W'(bb) : -W'(bb);
            end else if (s == S_SF + 1) begin
                m  = mag_f(r_st[s-1].y);
                hh = W'({i_cfg.hard_amount, 4'd0});
                bb = (m > hh) ? m - hh : '0;
                if (i_cfg.hard_amount != '0)
                    n_st[s].y = (r_st[s-1].y > 0) ? W'(bb) : -W'(bb);
            end else if (s == S_SF + 2) begin
                w  = (i_cfg.wet_mix > FULL_WET) ? FULL_WET : i_cfg.wet_mix;
                mx = (W+19)'(r_st[s-1].y) * $signed({1'b0, w})
                   + (W+19)'(r_st[s-1].x) * $signed({1'b0, 17'(FULL_WET - w)});
                if (w != FULL_WET) n_st[s].y = W'(mx >>> 16);
            end else if (s == S_SF + 3) begin
                sv = (r_st[s-1].y >>> SHL) <<< SHR;
                n_st[s].y = sv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NST; s++) r_st[s] <= '0;
        end else begin
            for (int s = 0; s < NST; s++) r_st[s] <= n_st[s];
        end
    end

    localparam logic signed [W-1:0] MAXV = W'((64'd1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [W-1:0] MINV = -MAXV - W'(1);

    assign o_valid  = r_st[NST-1].v;
    always_comb begin
        logic signed [W-1:0] y;
        y = r_st[NST-1].y;
        if (y > MAXV)      o_sample = SAMPLE_BITS'(MAXV);
        else if (y < MINV) o_sample = SAMPLE_BITS'(MINV);
        else               o_sample = SAMPLE_BITS'(y);
    end

endmodule

@@ rtl/core/stcs_checker.sv @@
// Port-level checks for the stereo triode crossover shaper.
// Bound to the top level below; it imports no package.
module stcs_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done,
    input logic o_cfg_ready
);
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy) else $error("busy raised");
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready) else $error("cfg not ready");
    a_no_done_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done || $past(i_rst_n)) else $error("done after reset");
endmodule

bind stereo_triode_crossover_shaper stcs_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_done(o_done), .o_cfg_ready(o_cfg_ready)
);

@@ verif/stereo_triode_crossover_shaper_tb.sv @@
// Self-checking testbench for the stereo triode crossover shaper.
// Depends on stcs_pkg and the stereo_triode_crossover_shaper top level.
// A scoreboard class predicts each shaped pair; tasks drive requests and register writes.
module stereo_triode_crossover_shaper_tb;
    import stcs_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int DRAIN       = 400;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_ITEMS  = 190;

    class shaper_scoreboard;
        t_out_item   pending[$];
        int          errors;
        logic [23:0] gain;
        logic [21:0] soft_amt;
        logic [21:0] hard;
        logic [16:0] wet;

        function new();
            errors = 0;
            gain = '0;
            soft_amt = '0;
            hard = '0;
            wet = '0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [31:0] data);
            case (idx)
                REG_TRIODE_GAIN: gain = data[23:0];
                REG_SOFT_AMOUNT: soft_amt = data[21:0];
                REG_HARD_AMOUNT: hard = data[21:0];
                REG_WET_MIX:     wet  = data[16:0];
                default: ;
            endcase
        endfunction

        function logic [63:0] mag(longint v);
            return v < 0 ? 64'(-v) : 64'(v);
        endfunction

        // Product shifted down without losing the top bits.
        function logic [63:0] mul_shr(logic [63:0] a, logic [63:0] b, int n);
            logic [63:0] lo;
            lo = a & ((64'd1 << n) - 64'd1);
            return (a >> n) * b + ((lo * b) >> n);
        endfunction

        // Truncated Taylor series of sine, nested from the highest term down.
        function logic [63:0] sine_q(logic [63:0] a);
            logic [63:0] x2;
            logic [63:0] t;
            logic [63:0] divs [6];
            divs = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
            x2 = (a * a) >> QB;
            t = 64'd1 << QB;
            for (int i = 0; i < 6; i++)
                t = (64'd1 << QB) - (((x2 * t) >> QB) / divs[i]);
            return (a * t) >> QB;
        endfunction

        function logic signed [23:0] shape(logic signed [23:0] raw);
            longint x;
            longint y;
            longint v;
            longint s;
            logic [63:0] g;
            logic [63:0] a;
            logic [63:0] b;
            logic [63:0] p;
            logic [63:0] rem;
            logic [63:0] root;
            logic [63:0] bitv;
            logic [63:0] w;
            x = longint'(raw) <<< 6;
            y = x;
            if (gain != 0) begin
                g = ({40'd0, gain} << 8) + 64'(GOFF_Q);
                p = mul_shr(mag(y), g, QB);
                v = (y < 0 ? -longint'(p) : longint'(p)) - longint'(HALF_Q);
                a = mag(v);
                if (a > 64'(PI2_Q))
                    a = 64'(PI2_Q);
                s = (v > 0 ? longint'(sine_q(a)) : -longint'(sine_q(a)))
                    + longint'(sine_q(64'(HALF_Q)));
                b = (mag(s) << QB) / g;
                y = s < 0 ? -longint'(b) : longint'(b);
            end
            if (soft_amt != 0) begin
                b = mag(y);
                // Bitwise integer square root of b scaled by 2^16.
                rem = b << 16;
                root = 0;
                bitv = 64'd1 << 62;
                while (bitv > rem)
                    bitv = bitv >> 2;
                while (bitv != 0) begin
                    if (rem >= root + bitv) begin
                        rem = rem - (root + bitv);
                        root = (root >> 1) + bitv;
                    end else begin
                        root = root >> 1;
                    end
                    bitv = bitv >> 2;
                end
                p = mul_shr(b + (root << 6), {42'd0, soft_amt}, 24);
                b = b > p ? b - p : 0;
                y = y > 0 ? longint'(b) : -longint'(b);
            end
            if (hard != 0) begin
                b = mag(y);
                b = b > ({42'd0, hard} << 4) ? b - ({42'd0, hard} << 4) : 0;
                y = y > 0 ? longint'(b) : -longint'(b);
            end
            w = wet > FULL_WET ? 64'(FULL_WET) : 64'(wet);
            if (w != 64'(FULL_WET))
                y = (y * longint'(w) + x * longint'(64'(FULL_WET) - w)) >>> 16;
            y = y >>> 6;
            if (y > 64'sd8388607)
                y = 64'sd8388607;
            if (y < -64'sd8388608)
                y = -64'sd8388608;
            return y[23:0];
        endfunction

        function void note_request(t_in_item it);
            t_out_item e;
            e.left_out = shape(it.left_sample);
            e.right_out = shape(it.right_sample);
            pending.push_back(e);
        endfunction

        function void check_result(t_out_item got);
            t_out_item e;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %h", $time, got);
                return;
            end
            e = pending.pop_front();
            if (got.left_out !== e.left_out) begin
                errors++;
                $display("%0t: left_out expected %0d actual %0d", $time, e.left_out,
                         got.left_out);
            end
            if (got.right_out !== e.right_out) begin
                errors++;
                $display("%0t: right_out expected %0d actual %0d", $time, e.right_out,
                         got.right_out);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in_item    i_item;
    logic        o_done;
    t_out_item   o_item;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    shaper_scoreboard sb;
    int cycles;
    int gap_pct;

    stereo_triode_crossover_shaper uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_done      (o_done),
        .o_item      (o_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                sb.note_request(i_item);
            if (o_done)
                sb.check_result(o_item);
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready)
                break;
        end
        sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic load_regs(logic [31:0] g, logic [31:0] s, logic [31:0] h,
                             logic [31:0] w);
        write_reg(REG_TRIODE_GAIN, g);
        write_reg(REG_SOFT_AMOUNT, s);
        write_reg(REG_HARD_AMOUNT, h);
        write_reg(REG_WET_MIX, w);
    endtask

    // Holds each request until the block takes it, with random idle cycles first.
    task automatic send_pair(logic [23:0] l, logic [23:0] r);
        @(negedge i_clk);
        while ($urandom_range(99) < gap_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start = 1'b1;
        i_item.left_sample = l;
        i_item.right_sample = r;
        forever begin
            @(posedge i_clk);
            if (!busy)
                break;
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        start = 1'b0;
        while (sb.pending.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
    endtask

    function automatic logic [23:0] rand_sample();
        case ($urandom_range(3))
            0: return 24'($urandom_range(255)) ^ {24{$urandom_range(1) == 1}};
            1: return 24'($urandom_range(24'h3FFFFF)) ^ {24{$urandom_range(1) == 1}};
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_amount(int bits, logic [31:0] top);
        case ($urandom_range(3))
            0: return 32'($urandom_range(top));
            1: return 32'($urandom_range(top >> 6));
            2: return 32'($urandom) & ((32'd1 << bits) - 1);
            default: return top;
        endcase
    endfunction

    initial begin
        logic [23:0] edges [10];
        sb = new();
        cycles = 0;
        gap_pct = 9;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_TRIODE_GAIN;
        i_cfg_data = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        edges = '{24'h000000, 24'h000001, 24'hFFFFFF, 24'h7FFFFF, 24'h800000,
                  24'h400000, 24'hC00000, 24'h200000, 24'h000040, 24'hFFFFC0};

        // Reset settings pass the input straight through.
        for (int i = 0; i < 10; i++)
            send_pair(edges[i], edges[9 - i]);
        wait_idle();

        for (int ph = 0; ph < 9; ph++) begin
            gap_pct = ph < 3 ? 9 : (ph < 6 ? 56 : 0);
            case (ph)
                0: load_regs(32'd8388608, 0, 0, 32'd65536);
                1: load_regs(32'hFFFFFF, 32'h3FFFFF, 32'h3FFFFF, 32'd131071);
                2: load_regs(0, 32'd2097152, 0, 32'd65536);
                3: load_regs(0, 0, 32'd2097152, 32'd32768);
                4: load_regs(32'd1, 32'd1, 32'd1, 32'd1);
                5: load_regs(32'd524288, 32'd65536, 32'd4096, 32'd49152);
                default: load_regs(rand_amount(24, 32'd8388608),
                                   rand_amount(22, 32'd2097152),
                                   rand_amount(22, 32'd2097152),
                                   rand_amount(17, 32'd65536));
            endcase
            for (int i = 0; i < 10; i++)
                send_pair(edges[i], edges[(i + 3) % 10]);
            for (int i = 0; i < RAND_ITEMS; i++)
                send_pair(rand_sample(), rand_sample());
            wait_idle();
        end

        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

@@ sim.f @@
rtl/core/stcs_pkg.sv
rtl/core/stcs_channel.sv
rtl/core/stereo_triode_crossover_shaper.sv
rtl/core/stcs_checker.sv
verif/stereo_triode_crossover_shaper_tb.sv
